@@ rtl/skvb_pkg.sv @@
package skvb_pkg;

  localparam int ADDR_W    = 12;
  localparam int ROW_W     = 50;
  localparam int ACC_W     = 51;
  localparam int SUM_W     = 35;
  localparam int NUM_W     = ACC_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = 6;
  localparam int TOT_W     = 19;
  localparam int IN_DATA_W = 248;
  localparam int OUT_DATA_W = 192;

  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    CFG_BONE_COUNT = 2'd0,
    CFG_PADDING    = 2'd1,
    CFG_EPSILON    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/skvb_mul.sv @@
module skvb_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end
endmodule

@@ rtl/skvb_div.sv @@
module skvb_div (
  input  logic                clk,
  input  logic                rst,
  input  skvb_pkg::div_req_t  req,
  output skvb_pkg::div_rsp_t  rsp
);
  import skvb_pkg::*;

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [NUM_W-1:0]       num_sh;
  logic [SUM_W-1:0]       den_mag;
  logic [SUM_W-1:0]       rem;
  logic [NUM_W-1:0]       quo;
  logic                   neg;
  logic [SUM_W:0]         rem_sh;
  logic                   fits;

  assign rem_sh = {rem, num_sh[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(DIV_STEPS);
        num_sh  <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        den_mag <= req.den[SUM_W-1] ? SUM_W'(-req.den) : SUM_W'(req.den);
        rem     <= '0;
        quo     <= '0;
        neg     <= req.num[NUM_W-1] ^ req.den[SUM_W-1];
      end else if (busy) begin
        // one quotient bit per cycle
        rem    <= fits ? SUM_W'(rem_sh - {1'b0, den_mag}) : rem_sh[SUM_W-1:0];
        quo    <= {quo[NUM_W-2:0], fits};
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (!neg) begin
      rsp.quot = (quo > NUM_W'(32'h7fffffff)) ? S32_MAX : signed'(quo[31:0]);
    end else begin
      rsp.quot = (quo > NUM_W'(33'h080000000)) ? S32_MIN : signed'(32'(-quo[31:0]));
    end
  end
endmodule

@@ rtl/skinned_vertex_bounds_core.sv @@
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | s_tdata, s_tuser = opcode, s_tlast = last_vertex
// m       | out       | m_tvalid/m_tready  | m_tdata = padded box
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
// A load item is written to the store as it is accepted, and input stays ready. A vertex is
// accepted, then each influence is checked; each used influence runs 4 rows of 4 products,
// each row then scaled by the weight, on the shared multiplier. Then the divide condition is
// checked, the serial divider runs per axis when it applies, then the box is updated and emitted.
// rst is synchronous: box returns to empty, registers to their reset values.
// The result sits in an output register; only a second last vertex waits on it.
module skinned_vertex_bounds_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] matrix_address, [43:12] matrix_value, [75:44] pos_x, [107:76] pos_y,
  // [139:108] pos_z, [157:140] weight_a, [175:158] weight_b, [193:176] weight_c,
  // [211:194] weight_d, [243:212] bone_indices, [247:244] zero
  input  logic [skvb_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] opcode
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] min_x, [63:32] min_y, [95:64] min_z, [127:96] max_x,
  // [159:128] max_y, [191:160] max_z
  output logic [skvb_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import skvb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_INF    = 12'b000000000010,
    S_RD     = 12'b000000000100,
    S_MUL    = 12'b000000001000,
    S_ADD    = 12'b000000010000,
    S_WMUL   = 12'b000000100000,
    S_WACC   = 12'b000001000000,
    S_DCHK   = 12'b000010000000,
    S_DSTART = 12'b000100000000,
    S_DWAIT  = 12'b001000000000,
    S_BOX    = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [8:0]  bone_count;
  logic [16:0] bounds_padding;
  logic [15:0] epsilon;

  logic [31:0] store [0:(1 << ADDR_W)-1];
  logic [31:0] rd_data;

  logic [1:0] jx, rx, cx, kx;
  logic signed [31:0] rest [3];
  logic signed [31:0] pos  [3];
  logic signed [17:0] wt   [4];
  logic [31:0] bidx;
  logic        last;
  logic signed [ROW_W-1:0] row;
  logic signed [ACC_W-1:0] acc [4];
  logic [TOT_W-1:0] total;
  logic signed [31:0] run_min [3];
  logic signed [31:0] run_max [3];

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               mul_en;
  logic signed [63:0] prod_rnd;
  logic signed [31:0] row_sat;
  logic signed [17:0] wcur;
  logic [7:0]         bone;
  logic               skip;
  logic signed [SUM_W-1:0] sum [4];
  logic [SUM_W-1:0]   sw_mag;
  logic               div_ok;
  logic [ADDR_W-1:0]  rd_addr;
  logic signed [32:0] pad_min [3];
  logic signed [32:0] pad_max [3];

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count     <= 9'd0;
      bounds_padding <= 17'd3277;
      epsilon        <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BONE_COUNT: bone_count     <= cfg_data[8:0];
        CFG_PADDING:    bounds_padding <= cfg_data;
        CFG_EPSILON:    epsilon        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign rd_addr = {bone, rx, cx};

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && !s_tuser) begin
      store[s_tdata[11:0]] <= s_tdata[43:12];
    end
    if (state == S_RD) begin
      rd_data <= store[rd_addr];
    end
  end

  assign wcur = wt[jx];
  assign bone = bidx[{jx, 3'b000} +: 8];
  assign skip = (wcur <= 18'sd0) || (!bone_count[8] && bone >= bone_count[7:0]);

  assign mul_en = (state == S_MUL) || (state == S_WMUL);
  assign row_sat = (row > ROW_W'(S32_MAX)) ? S32_MAX :
                   (row < ROW_W'(S32_MIN)) ? S32_MIN : row[31:0];
  always_comb begin
    if (state == S_WMUL) begin
      mul_a = row_sat;
      mul_b = 32'(wcur);
    end else begin
      mul_a = signed'(rd_data);
      mul_b = (cx == 2'd3) ? Q_ONE : rest[cx];
    end
  end

  skvb_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p));

  // round half up to Q16.16
  assign prod_rnd = (mul_p + 64'sd32768) >>> 16;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = SUM_W'((acc[i] + ACC_W'(32768)) >>> 16);
    end
  end
  assign sw_mag = sum[3][SUM_W-1] ? SUM_W'(-sum[3]) : SUM_W'(sum[3]);
  assign div_ok = (total > TOT_W'(epsilon)) && (sw_mag > SUM_W'(epsilon));

  always_comb begin
    div_req.start = (state == S_DSTART);
    div_req.num   = NUM_W'(sum[kx]) <<< 16;
    div_req.den   = sum[3];
  end

  skvb_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pad_min[i] = 33'(run_min[i]) - 33'(signed'({16'd0, bounds_padding}));
      pad_max[i] = 33'(run_max[i]) + 33'(signed'({16'd0, bounds_padding}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_min[i] <= S32_MAX;
        run_max[i] <= S32_MIN;
      end
    end else begin
      // drop the result once taken, unless a new box replaces it this cycle
      if (m_tvalid && m_tready && !(state == S_EMIT && last && bone_count != 9'd0)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser) begin
            rest[0] <= s_tdata[75:44];
            rest[1] <= s_tdata[107:76];
            rest[2] <= s_tdata[139:108];
            pos[0]  <= s_tdata[75:44];
            pos[1]  <= s_tdata[107:76];
            pos[2]  <= s_tdata[139:108];
            wt[0]   <= s_tdata[157:140];
            wt[1]   <= s_tdata[175:158];
            wt[2]   <= s_tdata[193:176];
            wt[3]   <= s_tdata[211:194];
            bidx    <= s_tdata[243:212];
            last    <= s_tlast;
            for (int i = 0; i < 4; i++) acc[i] <= '0;
            total   <= '0;
            jx      <= 2'd0;
            state   <= S_INF;
          end
        end
        S_INF: begin
          rx  <= 2'd0;
          cx  <= 2'd0;
          row <= '0;
          if (!skip) begin
            state <= S_RD;
          end else if (jx == 2'd3) begin
            state <= S_DCHK;
          end else begin
            jx <= jx + 2'd1;
          end
        end
        S_RD:  state <= S_MUL;
        S_MUL: state <= S_ADD;
        S_ADD: begin
          row <= row + ROW_W'(prod_rnd);
          if (cx == 2'd3) begin
            state <= S_WMUL;
          end else begin
            cx    <= cx + 2'd1;
            state <= S_RD;
          end
        end
        S_WMUL: state <= S_WACC;
        S_WACC: begin
          acc[rx] <= acc[rx] + ACC_W'(mul_p);
          row     <= '0;
          cx      <= 2'd0;
          if (rx == 2'd3) begin
            total <= total + TOT_W'(wcur);
            if (jx == 2'd3) begin
              state <= S_DCHK;
            end else begin
              jx    <= jx + 2'd1;
              state <= S_INF;
            end
          end else begin
            rx    <= rx + 2'd1;
            state <= S_RD;
          end
        end
        S_DCHK: begin
          kx    <= 2'd0;
          state <= div_ok ? S_DSTART : S_BOX;
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_rsp.done) begin
            pos[kx] <= div_rsp.quot;
            if (kx == 2'd2) begin
              state <= S_BOX;
            end else begin
              kx    <= kx + 2'd1;
              state <= S_DSTART;
            end
          end
        end
        S_BOX: begin
          for (int i = 0; i < 3; i++) begin
            if (pos[i] < run_min[i]) run_min[i] <= pos[i];
            if (pos[i] > run_max[i]) run_max[i] <= pos[i];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (bone_count == 9'd0 || !m_tvalid || m_tready) begin
            if (bone_count != 9'd0) begin
              m_tvalid <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                m_tdata[32*i +: 32] <= (pad_min[i] < 33'(S32_MIN)) ? S32_MIN
                                                                   : pad_min[i][31:0];
                m_tdata[32*(i+3) +: 32] <= (pad_max[i] > 33'(S32_MAX)) ? S32_MAX
                                                                       : pad_max[i][31:0];
              end
            end
            for (int i = 0; i < 3; i++) begin
              run_min[i] <= S32_MAX;
              run_max[i] <= S32_MIN;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/skvb_checker.sv @@
module skvb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [skvb_pkg::OUT_DATA_W-1:0] m_tdata
);
  import skvb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("load item did not finish in one cycle");

  a_vertex_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("vertex item did not hold off input");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[127:96])) &&
                 ($signed(m_tdata[63:32]) <= $signed(m_tdata[159:128])) &&
                 ($signed(m_tdata[95:64]) <= $signed(m_tdata[191:160])))
    else $error("box minimum above maximum");
endmodule

bind skinned_vertex_bounds_core skvb_checker u_skvb_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ test/tb.sv @@
module tb;
  import skvb_pkg::*;

  localparam int QUIET_LIMIT = 6000;
  localparam int SETTLE = 400;

  typedef enum int {MK_IDENT, MK_NICE, MK_FLAT, MK_HALF, MK_WILD} mat_kind_t;

  // Predicts the padded box for each mesh and holds the boxes still due.
  class bounds_scoreboard;
    logic signed [31:0] store [4096];
    bit written [4096];
    longint lo [3];
    longint hi [3];
    int unsigned bone_count = 0;
    int unsigned padding = 3277;
    int unsigned eps = 1;
    logic [OUT_DATA_W-1:0] boxes_due [$];
    int errors = 0;
    int boxes_seen = 0;

    function new();
      clear_box();
    endfunction

    function void clear_box();
      for (int i = 0; i < 3; i++) begin
        lo[i] = 64'sh7fffffff;
        hi[i] = -64'sh80000000;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, int unsigned v);
      case (idx)
        CFG_BONE_COUNT: bone_count = v & 'h1ff;
        CFG_PADDING:    padding = v & 'h1ffff;
        CFG_EPSILON:    eps = v & 'hffff;
        default: ;
      endcase
    endfunction

    function int unsigned eff_bones();
      return bone_count < 256 ? bone_count : 256;
    endfunction

    function bit bone_ready(int unsigned b);
      for (int i = 0; i < 16; i++)
        if (!written[b*16+i]) return 0;
      return 1;
    endfunction

    function longint rnd16(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function longint sat(longint v);
      if (v > 64'sh7fffffff) return 64'sh7fffffff;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function void note_input(logic [IN_DATA_W-1:0] d, logic op, logic last);
      longint p [4];
      longint acc [4];
      longint s [4];
      longint pos [3];
      longint w, row, total, m, mag;
      int unsigned nb, b;
      logic [31:0] r0, r1, r2, r3, r4, r5;
      if (!op) begin
        store[d[11:0]] = d[43:12];
        written[d[11:0]] = 1;
        return;
      end
      nb = eff_bones();
      total = 0;
      for (int r = 0; r < 4; r++) acc[r] = 0;
      p[0] = $signed(d[75:44]);
      p[1] = $signed(d[107:76]);
      p[2] = $signed(d[139:108]);
      p[3] = 65536;
      for (int r = 0; r < 3; r++) pos[r] = p[r];
      for (int j = 0; j < 4; j++) begin
        w = $signed(d[140+18*j +: 18]);
        b = d[212+8*j +: 8];
        if (w <= 0 || b >= nb) continue;
        for (int r = 0; r < 4; r++) begin
          row = 0;
          for (int c = 0; c < 4; c++) begin
            m = store[b*16 + r*4 + c];
            row += rnd16(m * p[c]);
          end
          acc[r] += sat(row) * w;
        end
        total += w;
      end
      for (int r = 0; r < 4; r++) s[r] = rnd16(acc[r]);
      mag = s[3] < 0 ? -s[3] : s[3];
      if (total > longint'(eps) && mag > longint'(eps))
        for (int r = 0; r < 3; r++) pos[r] = sat((s[r] * 65536) / s[3]);
      for (int r = 0; r < 3; r++) begin
        if (pos[r] < lo[r]) lo[r] = pos[r];
        if (pos[r] > hi[r]) hi[r] = pos[r];
      end
      if (!last) return;
      if (nb != 0) begin
        r0 = sat(lo[0] - padding);
        r1 = sat(lo[1] - padding);
        r2 = sat(lo[2] - padding);
        r3 = sat(hi[0] + padding);
        r4 = sat(hi[1] + padding);
        r5 = sat(hi[2] + padding);
        boxes_due.insert(boxes_due.size(), {r5, r4, r3, r2, r1, r0});
      end
      clear_box();
    endfunction

    function void check_box(logic [OUT_DATA_W-1:0] got);
      string names [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
      logic [OUT_DATA_W-1:0] want;
      boxes_seen++;
      if (boxes_due.size() == 0) begin
        $error("box %h arrived with none pending", got);
        errors++;
        return;
      end
      want = boxes_due.pop_front();
      for (int f = 0; f < 6; f++)
        if (want[32*f +: 32] !== got[32*f +: 32]) begin
          $error("%s: expected %h, got %h", names[f], want[32*f +: 32], got[32*f +: 32]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid, s_tready, s_tuser, s_tlast;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [16:0] cfg_data;

  bounds_scoreboard sb = new();
  int unsigned rig [7] = '{0, 1, 2, 3, 4, 5, 255};
  bit calm = 0;
  int hold_left = 0;
  int quiet = 0;
  int items_sent = 0;
  int settings_run = 0;

  always #4 clk = ~clk;

  skinned_vertex_bounds_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser, s_tlast);
    if (m_tvalid && m_tready) sb.check_box(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  // Result side: random stalls, or a long hold-off when asked.
  initial begin
    m_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 0;
        hold_left--;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  task automatic send(logic op, logic [IN_DATA_W-1:0] d, logic last);
    if (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tlast <= last;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic logic [IN_DATA_W-1:0] noise();
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < IN_DATA_W; i += 32) d[i +: 32] = $urandom;
    d[247:244] = 0;
    return d;
  endfunction

  task automatic load_word(logic [11:0] addr, logic [31:0] val, logic last);
    logic [IN_DATA_W-1:0] d;
    d = noise();
    d[11:0] = addr;
    d[43:12] = val;
    send(1'b0, d, last);
  endtask

  task automatic send_vertex(int px, int py, int pz, int w0, int w1, int w2, int w3,
                             logic [31:0] idx, logic last);
    logic [IN_DATA_W-1:0] d;
    logic signed [17:0] w [4];
    d = noise();
    w[0] = w0;
    w[1] = w1;
    w[2] = w2;
    w[3] = w3;
    d[75:44] = px;
    d[107:76] = py;
    d[139:108] = pz;
    for (int j = 0; j < 4; j++) d[140+18*j +: 18] = w[j];
    d[243:212] = idx;
    send(1'b1, d, last);
  endtask

  function automatic logic [31:0] word_for(mat_kind_t kind, int r, int c);
    if (kind == MK_WILD) return $urandom;
    if (kind == MK_IDENT) return (r == c) ? 32'd65536 : 32'd0;
    if (r == 3) begin
      if (kind == MK_FLAT) return 0;
      if (c != 3) return int'($urandom_range(0, 512)) - 256;
      return kind == MK_HALF ? 32768 : 65536 + int'($urandom_range(0, 8192)) - 4096;
    end
    if (r == c) return 65536 + int'($urandom_range(0, 65536)) - 32768;
    if (c == 3) return int'($urandom_range(0, 1 << 24)) - (1 << 23);
    return int'($urandom_range(0, 65536)) - 32768;
  endfunction

  task automatic load_bone(int unsigned b, mat_kind_t kind);
    for (int e = 0; e < 16; e++) load_word({b[7:0], e[3:0]}, word_for(kind, e / 4, e % 4), 0);
  endtask

  task automatic rand_item();
    int b, wi, k;
    int p [3];
    int w [4];
    logic [31:0] idx;
    k = $urandom_range(0, 99);
    if (k < 18) begin
      b = rig[$urandom_range(0, 6)];
      wi = $urandom_range(0, 15);
      load_word({b[7:0], wi[3:0]},
                word_for($urandom_range(0, 4) == 0 ? MK_WILD : MK_NICE, wi / 4, wi % 4),
                $urandom_range(0, 1));
    end else if (k < 25) begin
      load_word($urandom_range(0, 4095), $urandom, $urandom_range(0, 1));
    end else begin
      for (int j = 0; j < 4; j++) begin
        b = ($urandom_range(0, 9) < 7) ? rig[$urandom_range(0, 6)] : $urandom_range(0, 255);
        if ($urandom_range(0, 9) < 7) wi = $urandom_range(1, 65536);
        else wi = -int'($urandom_range(0, 65536));
        // never read a matrix that is not fully loaded
        if (wi > 0 && b < sb.eff_bones() && !sb.bone_ready(b)) wi = -wi;
        w[j] = wi;
        idx[8*j +: 8] = b;
      end
      for (int r = 0; r < 3; r++)
        p[r] = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                           : int'($urandom_range(0, 1 << 22)) - (1 << 21);
      send_vertex(p[0], p[1], p[2], w[0], w[1], w[2], w[3], idx, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.boxes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic new_setting(int unsigned bones, int unsigned pad, int unsigned e);
    drain();
    write_reg(CFG_BONE_COUNT, bones);
    write_reg(CFG_PADDING, pad);
    write_reg(CFG_EPSILON, e);
    settings_run++;
  endtask

  initial begin
    s_tvalid <= 0;
    s_tuser <= 0;
    s_tlast <= 0;
    s_tdata <= '0;
    cfg_valid <= 0;
    cfg_index <= CFG_BONE_COUNT;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset registers: no bones, so a last vertex only clears the box.
    load_bone(0, MK_IDENT);
    send_vertex(100, -200, 300, 65536, 0, 0, 0, 32'h0, 1);
    load_bone(1, MK_NICE);
    load_bone(2, MK_FLAT);
    load_bone(3, MK_WILD);
    load_bone(4, MK_HALF);
    load_bone(5, MK_NICE);
    load_bone(255, MK_NICE);
    load_word(12'hfff, $urandom, 1);

    new_setting(256, 65536, 1);
    send_vertex(32'h7fffffff, 32'h80000000, 0, 65536, 0, 0, 0, 32'h0, 0);
    send_vertex(1, 2, 3, -65536, -65536, -65536, -65536, 32'h01020300, 1);
    send_vertex(32'h80000000, 32'h7fffffff, -5, 65536, 0, -1, 0, 32'h00000002, 1);
    send_vertex(65536, -65536, 131072, 32768, 32768, 0, 0, 32'h000001ff, 1);
    send_vertex(70000, 80000, -90000, 65536, 0, 0, 0, 32'h00000004, 0);
    send_vertex(-3, 4, 5, 16384, 16384, 16384, 16384, 32'h05040301, 1);
    repeat (170) rand_item();

    new_setting(3, 0, 0);
    send_vertex(1000, 2000, 3000, 65536, 65536, 65536, 65536, 32'h02c80100, 1);
    send_vertex(-1, -1, -1, 0, 0, 0, 65536, 32'h03000000, 1);
    repeat (170) rand_item();

    new_setting(511, 3277, 65535);
    repeat (170) rand_item();

    new_setting(0, 100, 5);
    repeat (40) rand_item();

    calm = 1;
    new_setting(256, 3277, 1);
    repeat (170) rand_item();
    calm = 0;

    new_setting(7, 1000, 16);
    hold_left = 800;
    repeat (170) rand_item();

    drain();
    $display("tb: %0d items sent over %0d register settings, %0d boxes checked",
             items_sent, settings_run, sb.boxes_seen);
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
